[hdl/assert_macros.svh]
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lpgc_pkg.sv]
package lpgc_pkg;

    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 12;
    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INCREMENTED = 2'd0;
    localparam t_status ST_INSERTED    = 2'd1;
    localparam t_status ST_FULL        = 2'd2;
    localparam t_status ST_REJECTED    = 2'd3;

    localparam t_count COUNT_MAX = '1;

endpackage

[hdl/lpgc_in_if.sv]
interface lpgc_in_if;
    import lpgc_pkg::*;

    logic  valid;
    logic  ready;
    t_key  key;
    t_slot home_slot;
    logic  last_key;

    modport source (output valid, output key, output home_slot, output last_key, input ready);
    modport sink   (input valid, input key, input home_slot, input last_key, output ready);
endinterface

[hdl/lpgc_out_if.sv]
interface lpgc_out_if;
    import lpgc_pkg::*;

    logic    valid;
    logic    ready;
    t_slot   slot;
    t_count  count;
    t_status status;
    logic    last_result;

    modport source (output valid, output slot, output count, output status,
                    output last_result, input ready);
    modport sink   (input valid, input slot, input count, input status,
                    input last_result, output ready);
endinterface

[hdl/lpgc_cfg_if.sv]
interface lpgc_cfg_if;
    import lpgc_pkg::*;

    logic  valid;
    logic  ready;
    t_size table_size;

    modport source (output valid, output table_size, input ready);
    modport sink   (input valid, input table_size, output ready);
endinterface

[hdl/linear_probe_group_count.sv]
// Group-by counter over an open-addressed hash table with linear probing.
// i_in beats carry a key, its precomputed home slot and an end-of-batch flag.
// Every input beat yields exactly one o_out beat: the slot found or filled,
// the key's saturating count, a status code and the echoed batch flag.
// Zero keys and home slots at or above the table size are rejected without
// touching the table; a table with no match and no free slot reports full.
// i_cfg writes the table size at any time; it should only be changed while
// the block holds no item. Sizes above TABLE_DEPTH are used as TABLE_DEPTH.
// After reset a clearing pass zeroes the table memory, one entry per cycle;
// no input beat is taken until it has finished.
// Probing: the memory read for the home slot is issued in the accept cycle and
// each probe then reads the table memory, which has one read and one write
// port; the result is loaded into the output register once the item resolves.
// Items follow each other without a gap, so a run of first-probe hits sustains
// one item per cycle while the output is not stalled.
// A single output register holds the result; while it is stalled the engine
// holds its probe and accepts nothing further.
module linear_probe_group_count #(
    parameter int TABLE_DEPTH = 4096,
    parameter int KEY_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpgc_in_if.sink     i_in,
    lpgc_out_if.source  o_out,
    lpgc_cfg_if.sink    i_cfg
);
    import lpgc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;
    localparam int WW = KEY_BITS + COUNT_W;
    localparam int RESET_SIZE = (TABLE_DEPTH < 4096) ? TABLE_DEPTH : 4096;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    typedef logic [AW-1:0]       t_addr;
    typedef logic [SW-1:0]       t_tsize;
    typedef logic [KEY_BITS-1:0] t_mkey;
    typedef logic [WW-1:0]       t_word;

    // Table memory: each word holds {count, key}; a zero key marks an empty slot.
    t_word mem [TABLE_DEPTH];
    t_word r_mem_q;

    logic [1:0] r_state, n_state;
    t_addr      r_clr_addr;
    t_tsize     r_size;
    t_mkey      r_key;
    logic       r_last;
    logic       r_reject;
    t_addr      r_pos;
    t_tsize     r_probes;
    logic       r_fwd_hit;
    t_word      r_fwd_data;

    logic       r_out_valid;
    t_slot      r_out_slot;
    t_count     r_out_count;
    t_status    r_out_status;
    logic       r_out_last;

    logic [63:0] w_key_ext;
    t_mkey       w_key_m;
    logic [31:0] w_home32;
    t_addr       w_home_addr;
    logic        w_in_reject;
    logic        w_in_acc;
    logic        w_out_free;

    t_word       w_q;
    t_mkey       w_q_key;
    t_count      w_q_count;
    t_count      w_inc_count;
    logic        w_in_check;
    logic        w_hit;
    logic        w_empty;
    logic        w_full;
    logic        w_resolve;
    logic        w_done;
    logic        w_advance;
    t_tsize      w_pos_inc;
    t_addr       w_next_pos;
    logic [31:0] w_pos32;

    logic        w_chk_wr;
    logic        w_wr_en;
    t_addr       w_wr_addr;
    t_word       w_wr_data;
    t_addr       w_rd_addr;

    logic [31:0] w_cfg32;
    t_tsize      w_cfg_size;

    // Input decode.
    always_comb begin
        w_key_ext   = 64'(i_in.key);
        w_key_m     = w_key_ext[KEY_BITS-1:0];
        w_home32    = 32'(i_in.home_slot);
        w_home_addr = w_home32[AW-1:0];
        w_in_reject = (w_key_m == '0) || (w_home32 >= 32'(r_size));
    end

    // Probe evaluation; a write in the previous cycle to the same entry is forwarded.
    always_comb begin
        w_q         = r_fwd_hit ? r_fwd_data : r_mem_q;
        w_q_key     = w_q[KEY_BITS-1:0];
        w_q_count   = w_q[WW-1:KEY_BITS];
        w_inc_count = (w_q_count == COUNT_MAX) ? COUNT_MAX : w_q_count + 1'b1;
        w_in_check  = (r_state == S_CHECK);
        w_hit       = !r_reject && (w_q_key == r_key);
        w_empty     = !r_reject && (w_q_key == '0);
        w_full      = !r_reject && !w_hit && !w_empty && ((r_probes + 1'b1) == r_size);
        w_resolve   = r_reject || w_hit || w_empty || w_full;
        w_out_free  = !r_out_valid || o_out.ready;
        w_done      = w_in_check && w_resolve && w_out_free;
        w_advance   = w_in_check && !w_resolve;
        w_pos_inc   = SW'(r_pos) + 1'b1;
        w_next_pos  = (w_pos_inc >= r_size) ? '0 : w_pos_inc[AW-1:0];
        w_pos32     = 32'(r_pos);
    end

    assign i_in.ready  = (r_state == S_IDLE) || w_done;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Memory port selection.
    always_comb begin
        w_chk_wr = w_done && (w_hit || w_empty);
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = w_chk_wr;
            w_wr_addr = r_pos;
            w_wr_data = w_hit ? {w_inc_count, r_key} : {t_count'(1), r_key};
        end
        if (w_in_acc) begin
            w_rd_addr = w_home_addr;
        end else if (w_advance) begin
            w_rd_addr = w_next_pos;
        end else begin
            w_rd_addr = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_mem_q    <= mem[w_rd_addr];
        r_fwd_data <= w_wr_data;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_done && !w_in_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        w_cfg32    = 32'(i_cfg.table_size);
        w_cfg_size = (w_cfg32 > 32'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(w_cfg32);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_size      <= SW'(RESET_SIZE);
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fwd_hit <= w_wr_en && (w_wr_addr == w_rd_addr);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg.valid) begin
                r_size <= w_cfg_size;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key    <= w_key_m;
            r_last   <= i_in.last_key;
            r_reject <= w_in_reject;
            r_pos    <= w_home_addr;
            r_probes <= '0;
        end else if (w_advance) begin
            r_pos    <= w_next_pos;
            r_probes <= r_probes + 1'b1;
        end
        if (w_done) begin
            r_out_last <= r_last;
            if (r_reject) begin
                r_out_slot   <= '0;
                r_out_count  <= '0;
                r_out_status <= ST_REJECTED;
            end else if (w_hit) begin
                r_out_slot   <= w_pos32[SLOT_W-1:0];
                r_out_count  <= w_inc_count;
                r_out_status <= ST_INCREMENTED;
            end else if (w_empty) begin
                r_out_slot   <= w_pos32[SLOT_W-1:0];
                r_out_count  <= t_count'(1);
                r_out_status <= ST_INSERTED;
            end else begin
                r_out_slot   <= '0;
                r_out_count  <= '0;
                r_out_status <= ST_FULL;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.slot        = r_out_slot;
    assign o_out.count       = r_out_count;
    assign o_out.status      = r_out_status;
    assign o_out.last_result = r_out_last;

`include "assert_macros.svh"

    `ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n,
                 r_state == S_CLEAR, !i_in.ready, "beat accepted during clearing pass")
    `ASSERT_SAME(a_reject_no_write, i_clk, i_rst_n,
                 w_in_check && r_reject, !w_chk_wr, "rejected item wrote the table")
    `ASSERT_SAME(a_fwd_after_write, i_clk, i_rst_n,
                 r_fwd_hit, $past(w_wr_en), "forwarding without a write")
    `ASSERT_SAME(a_probe_bound, i_clk, i_rst_n,
                 w_in_check, r_reject || (r_probes < r_size), "probe count beyond table size")
    `ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n,
                 w_done, r_out_valid, "resolved item gave no result")

endmodule
